/* hw/rtl/gbi_pkg.sv */
// Shared types and constants for the gap buffer byte insert block.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package gbi_pkg;

  // Default text store capacity in bytes.
  localparam int unsigned CapacityDefault = 1024;

  // Fixed payload widths of the request and result channels.
  localparam int unsigned PosWidth    = 11;
  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned LenWidth    = 11;

  // Operation codes carried in the func field.
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  // Result status codes.
  typedef enum logic [StatusWidth-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } gbi_status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the request beat
    logic decode;  // classify the item, set up the gap move or issue the read
    logic move;    // advance the gap by one copy step
    logic finish;  // commit the insert and load the result beat
  } gbi_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go_move;    // insert that is not refused
    logic move_done;  // no copy left to issue or write
    logic out_free;   // result register can take a new beat
  } gbi_stat_t;

endpackage

/* hw/rtl/gbi_in_if.sv */
// Request channel interface: valid/ready handshake with func, position, data_byte.
// Depends on gbi_pkg for the payload widths.
`timescale 1ns / 1ps

interface gbi_in_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [gbi_pkg::PosWidth-1:0]   position;
  logic [gbi_pkg::ByteWidth-1:0]  data_byte;

  modport source (output valid, output func, output position, output data_byte,
                  input ready);
  modport sink (input valid, input func, input position, input data_byte,
                output ready);
endinterface

/* hw/rtl/gbi_out_if.sv */
// Result channel interface: valid/ready handshake with status, read_byte, text_length.
// Depends on gbi_pkg for the payload widths.
`timescale 1ns / 1ps

interface gbi_out_if;
  logic                             valid;
  logic                             ready;
  logic [gbi_pkg::StatusWidth-1:0]  status;
  logic [gbi_pkg::ByteWidth-1:0]    read_byte;
  logic [gbi_pkg::LenWidth-1:0]     text_length;

  modport source (output valid, output status, output read_byte, output text_length,
                  input ready);
  modport sink (input valid, input status, input read_byte, input text_length,
                output ready);
endinterface

/* hw/rtl/gbi_ctrl.sv */
// Controller state machine of the gap buffer block.
// Depends on gbi_pkg for the command and status structs.
`timescale 1ns / 1ps

module gbi_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  gbi_pkg::gbi_stat_t stat,
  output gbi_pkg::gbi_cmd_t  cmd
);
  import gbi_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DECODE = 4'b0010,
    ST_MOVE   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        state_next = stat.go_move ? ST_MOVE : ST_FINISH;
      end
      ST_MOVE: begin
        cmd.move = 1'b1;
        if (stat.move_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hw/rtl/gbi_datapath.sv */
// Datapath of the gap buffer block: text store, gap pointers, copy engine, result register.
// Depends on gbi_pkg and on the gbi_in_if / gbi_out_if channel interfaces.
`timescale 1ns / 1ps

module gbi_datapath #(
  parameter int unsigned CAPACITY = gbi_pkg::CapacityDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  gbi_pkg::gbi_cmd_t  cmd,
  output gbi_pkg::gbi_stat_t stat,
  gbi_in_if.sink             request,
  gbi_out_if.source          result
);
  import gbi_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned PW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (PW > PosWidth) ? PW : PosWidth;
  localparam logic [PW-1:0] CapW = PW'(CAPACITY);
  localparam logic [PW-1:0] OneW = PW'(1);

  // Latched request.
  logic                 op_func;
  logic [PosWidth-1:0]  op_pos;
  logic [ByteWidth-1:0] op_byte;

  // Gap and copy engine state.
  logic [PW-1:0] gap_begin;
  logic [PW-1:0] gap_finish;
  logic          mv_right;
  logic [PW-1:0] mv_cnt;
  logic [AW-1:0] rd_ptr;
  logic          wr_pend;
  gbi_status_t   res_status;

  // Text store.
  logic [ByteWidth-1:0] mem [CAPACITY];
  logic [ByteWidth-1:0] rdata;

  // Result register.
  logic                 out_valid;
  logic [StatusWidth-1:0] out_status;
  logic [ByteWidth-1:0] out_byte;
  logic [LenWidth-1:0]  out_len;

  // Derived quantities of the current gap.
  logic [PW-1:0] gap_size;
  logic [PW-1:0] len_now;
  logic [CW-1:0] pos_ext;
  logic [CW-1:0] len_ext;
  logic [CW-1:0] begin_ext;
  logic [CW-1:0] read_addr_ext;
  logic [PW-1:0] cursor;
  logic          full;
  logic          past_end;
  logic          go_read;
  logic          insert_ok;
  logic [PW-1:0] len_final;
  logic [CW-1:0] len_final_ext;

  assign gap_size  = gap_finish - gap_begin;
  assign len_now   = CapW - gap_size;
  assign full      = (gap_size == '0);
  assign pos_ext   = CW'(op_pos);
  assign len_ext   = CW'(len_now);
  assign begin_ext = CW'(gap_begin);
  assign past_end  = (pos_ext >= len_ext);
  assign cursor    = (pos_ext > len_ext) ? len_now : pos_ext[PW-1:0];
  assign go_read   = (op_func == FUNC_READ) && !past_end;
  assign read_addr_ext = (pos_ext < begin_ext) ? pos_ext : (pos_ext + CW'(gap_size));
  assign insert_ok = (op_func == FUNC_INSERT) && (res_status == STATUS_OK);
  assign len_final = insert_ok ? (len_now + OneW) : len_now;
  assign len_final_ext = CW'(len_final);

  assign stat.go_move   = (op_func == FUNC_INSERT) && !full;
  assign stat.move_done = (mv_cnt == '0) && !wr_pend;
  assign stat.out_free  = !out_valid || result.ready;

  // Memory port selection.
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [ByteWidth-1:0] wr_data;
  logic [PW-1:0]        finish_dec;

  assign finish_dec = gap_finish - OneW;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rd_ptr;
    wr_en   = 1'b0;
    wr_addr = gap_begin[AW-1:0];
    wr_data = rdata;
    if (cmd.decode && go_read) begin
      rd_en   = 1'b1;
      rd_addr = read_addr_ext[AW-1:0];
    end else if (cmd.move && (mv_cnt != '0)) begin
      rd_en = 1'b1;
    end
    if (cmd.move && wr_pend) begin
      wr_en   = 1'b1;
      wr_addr = mv_right ? gap_begin[AW-1:0] : finish_dec[AW-1:0];
    end else if (cmd.finish && insert_ok) begin
      wr_en   = 1'b1;
      wr_data = op_byte;
    end
  end

  // Text store with registered read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Request capture and result status.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_func <= request.func;
      op_pos  <= request.position;
      op_byte <= request.data_byte;
    end
    if (cmd.decode) begin
      if (op_func == FUNC_INSERT) begin
        res_status <= full ? STATUS_FULL : STATUS_OK;
      end else begin
        res_status <= past_end ? STATUS_RANGE : STATUS_OK;
      end
    end
  end

  // Gap pointers and copy engine: one read issued and one byte written per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_begin  <= '0;
      gap_finish <= CapW;
      mv_right   <= 1'b0;
      mv_cnt     <= '0;
      rd_ptr     <= '0;
      wr_pend    <= 1'b0;
    end else begin
      if (cmd.decode) begin
        wr_pend <= 1'b0;
        if (stat.go_move) begin
          mv_right <= (cursor > gap_begin);
          if (cursor > gap_begin) begin
            mv_cnt <= cursor - gap_begin;
            rd_ptr <= gap_finish[AW-1:0];
          end else begin
            mv_cnt <= gap_begin - cursor;
            rd_ptr <= gap_begin[AW-1:0] - AW'(1);
          end
        end else begin
          mv_cnt <= '0;
        end
      end
      if (cmd.move) begin
        wr_pend <= (mv_cnt != '0);
        if (mv_cnt != '0) begin
          mv_cnt <= mv_cnt - OneW;
          rd_ptr <= mv_right ? (rd_ptr + AW'(1)) : (rd_ptr - AW'(1));
        end
        if (wr_pend) begin
          if (mv_right) begin
            gap_begin  <= gap_begin + OneW;
            gap_finish <= gap_finish + OneW;
          end else begin
            gap_begin  <= gap_begin - OneW;
            gap_finish <= gap_finish - OneW;
          end
        end
      end
      if (cmd.finish && insert_ok) begin
        gap_begin <= gap_begin + OneW;
      end
    end
  end

  // Result register: holds the beat until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status <= res_status;
      out_byte   <= ((op_func == FUNC_READ) && (res_status == STATUS_OK)) ? rdata : '0;
      out_len    <= len_final_ext[LenWidth-1:0];
    end
  end

  assign result.valid       = out_valid;
  assign result.status      = out_status;
  assign result.read_byte   = out_byte;
  assign result.text_length = out_len;

  // The gap never inverts.
  a_gap_order: assert property (@(posedge clk) disable iff (rst)
    gap_begin <= gap_finish)
    else $error("gap_begin passed gap_finish");

  // A result beat is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || result.ready))
    else $error("result beat overwritten");

  // Every copy read is followed by its write in the next cycle.
  a_copy_write: assert property (@(posedge clk) disable iff (rst)
    (cmd.move && (mv_cnt != '0)) |=> (wr_pend && cmd.move))
    else $error("copy read without following write");

endmodule

/* hw/rtl/gap_buffer_byte_insert.sv */
// Gap buffer byte store: insert a byte at a clamped cursor, or read the byte at a text index.
// An accepted request is latched and decoded; a read or a refused insert then goes straight
// to the result stage, any other insert first through the copy stage that moves the gap to
// the cursor (at most CAPACITY - 1 bytes). Throughput: one item at a time; the copy engine
// moves one byte per cycle through the single-write, single-read text store. Synchronous
// reset clears the gap to the whole store (empty text); the store itself is not cleared.
`timescale 1ns / 1ps

module gap_buffer_byte_insert #(
  parameter int unsigned CAPACITY = gbi_pkg::CapacityDefault
) (
  input logic       clk,
  input logic       rst,
  gbi_in_if.sink    request,
  gbi_out_if.source result
);
  import gbi_pkg::*;

  gbi_cmd_t  cmd;
  gbi_stat_t stat;
  logic      ctrl_ready;

  // Sequencing of each item.
  gbi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (ctrl_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The request side is open whenever the controller is idle.
  assign request.ready = ctrl_ready;

  // Store, gap pointers and result register.
  gbi_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .request (request),
    .result  (result)
  );

endmodule
